@@ src/mws_pkg.sv @@
// Shared types, constants and helper functions for the multichannel window smoother.
// Used by every module and by the checker; depends on nothing else.
`default_nettype none

package mws_pkg;

    localparam int MAX_SITES  = 4096;
    localparam int SITE_W     = $clog2(MAX_SITES);
    localparam int NSITE_W    = SITE_W + 1;
    localparam int MAX_TAPS   = 16;
    localparam int SLOT_W     = $clog2(MAX_TAPS);
    localparam int TAPS_W     = SLOT_W + 1;
    localparam int LEN_W      = 5;
    localparam int PASS_W     = 4;
    localparam int DATA_W     = 32;
    localparam int WGT_W      = 16;
    localparam int ACC_W      = 48;
    localparam int DEN_W      = WGT_W + 1;
    localparam int QUO_W      = 33;
    localparam int QCNT_W     = $clog2(QUO_W);
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam int HIST_W     = 3 * DATA_W;
    localparam int ADDR_W     = SLOT_W + SITE_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NUM_SITES,
        CFG_WINDOW_LENGTH,
        CFG_TRIANGULAR,
        CFG_BINOMIAL_PASSES
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_BUILD,
        ST_IDLE,
        ST_ACC,
        ST_DIV,
        ST_HOLD
    } state_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] pos_x;
        logic signed [DATA_W-1:0] pos_y;
        logic signed [DATA_W-1:0] pos_z;
    } pos_item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] smooth_x;
        logic signed [DATA_W-1:0] smooth_y;
        logic signed [DATA_W-1:0] smooth_z;
        logic [SITE_W-1:0]        site_number;
        logic                     frame_last;
    } res_item_t;

    // Weight sum of a triangular window: m*m for odd length, m*(m+1) for even
    function automatic logic [WGT_W-1:0] tri_sum(input logic [LEN_W-1:0] len);
        logic [3:0] m;
        logic [7:0] p;
        m = 4'(({1'b0, len} + 6'd1) >> 1);
        if (len[0])
            p = 8'(m * m);
        else
            p = 8'(m * (m + 4'd1));
        return WGT_W'(p);
    endfunction

endpackage

`default_nettype wire

@@ src/multichannel_window_smoother_unit.sv @@
// Top level of the multichannel window smoother: history memory, weight builder,
// tap accumulator and control. Depends on mws_pkg and mws_div.
`default_nettype none

// Smooths each site's 3D position over frames with an FIR window of up to 16 taps.
// Positions are transferred frame by frame, site by site; the block holds one item at a time.
// An item that yields no result (the first taps-1 frames after a restart) is only written to history.
// An item that yields a result passes through the transfer, one history read per cycle
// from the history memory, the multiply and accumulate drain, the start of the dividers,
// the bit-serial rounding dividers and the hand-over of the result to the output register,
// which waits while a stalled result still occupies it.
// The result register lets the next item be transferred while a result waits. Any
// configuration write restarts the stream and rebuilds the weights, running the clamped
// number of binomial passes, during which no item is transferred.

module multichannel_window_smoother_unit (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 site_valid,
    output logic                                      site_stall,
    input  wire mws_pkg::pos_item_t                   site_pos,
    output logic                                      res_valid,
    input  wire logic                                 res_stall,
    output mws_pkg::res_item_t                        res_item,
    input  wire logic                                 cfg_wr_en,
    input  wire logic [mws_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [mws_pkg::CFG_DATA_W-1:0]       cfg_data
);

    // Configuration registers
    logic [mws_pkg::NSITE_W-1:0] num_sites_reg;
    logic [mws_pkg::LEN_W-1:0]   window_length_reg;
    logic                        triangular_reg;
    logic [mws_pkg::PASS_W-1:0]  passes_reg;

    // Derived configuration
    logic [mws_pkg::LEN_W-1:0]   len_eff;
    logic [mws_pkg::LEN_W-1:0]   room;
    logic [mws_pkg::PASS_W-1:0]  passes_eff;
    logic [mws_pkg::NSITE_W-1:0] sites_eff;
    logic [mws_pkg::WGT_W-1:0]   base_sum;
    logic [2*mws_pkg::WGT_W-1:0] dvs_wide;
    logic [mws_pkg::WGT_W-1:0]   base_wgt [mws_pkg::MAX_TAPS];

    // Weights and builder
    logic [mws_pkg::WGT_W-1:0]   wgts_reg [mws_pkg::MAX_TAPS];
    logic                        bld_init_reg;
    logic [mws_pkg::PASS_W-1:0]  bld_cnt_reg;
    logic [mws_pkg::TAPS_W-1:0]  taps_reg;
    logic [mws_pkg::WGT_W-1:0]   dvs_reg;

    // Stream position
    logic [mws_pkg::SITE_W-1:0]  site_cnt_reg;
    logic [mws_pkg::TAPS_W-1:0]  frames_reg;
    logic [mws_pkg::SLOT_W-1:0]  oldest_reg;

    // Per-item context
    logic [mws_pkg::SITE_W-1:0]  site_reg;
    logic [mws_pkg::SLOT_W-1:0]  base_reg;
    logic                        last_reg;
    logic [mws_pkg::TAPS_W-1:0]  rd_cnt_reg;

    // Accumulator pipeline
    logic                              iss_vld_reg;
    logic [mws_pkg::WGT_W-1:0]         wgt_pipe_reg;
    logic [mws_pkg::HIST_W-1:0]        rd_data_reg;
    logic                              prd_vld_reg;
    logic signed [mws_pkg::ACC_W-1:0]  prod_x_reg;
    logic signed [mws_pkg::ACC_W-1:0]  prod_y_reg;
    logic signed [mws_pkg::ACC_W-1:0]  prod_z_reg;
    logic signed [mws_pkg::ACC_W-1:0]  acc_x_reg;
    logic signed [mws_pkg::ACC_W-1:0]  acc_y_reg;
    logic signed [mws_pkg::ACC_W-1:0]  acc_z_reg;

    // History memory: one entry per (frame slot, site), x/y/z side by side
    logic [mws_pkg::HIST_W-1:0]  hist_mem [mws_pkg::MAX_TAPS * mws_pkg::MAX_SITES];
    logic [mws_pkg::ADDR_W-1:0]  wr_addr;
    logic [mws_pkg::ADDR_W-1:0]  rd_addr;
    logic [mws_pkg::SLOT_W-1:0]  cur_slot;
    logic [mws_pkg::SLOT_W-1:0]  rd_slot;

    // Control
    mws_pkg::state_t             state_reg;
    mws_pkg::state_t             state_next;
    logic                        accept;
    logic                        is_last;
    logic                        produce;
    logic                        issue_en;
    logic                        div_start;
    logic                        div_done;
    logic                        res_load;
    logic                        bld_pass;
    logic                        res_valid_reg;
    mws_pkg::res_item_t          res_item_reg;

    logic                              done_x;
    logic                              done_y;
    logic                              done_z;
    logic signed [mws_pkg::DATA_W-1:0] quo_x;
    logic signed [mws_pkg::DATA_W-1:0] quo_y;
    logic signed [mws_pkg::DATA_W-1:0] quo_z;

    // Clamp the configuration
    always_comb
    begin
        if (window_length_reg == '0)
            len_eff = mws_pkg::LEN_W'(1);
        else if (window_length_reg > mws_pkg::LEN_W'(mws_pkg::MAX_TAPS))
            len_eff = mws_pkg::LEN_W'(mws_pkg::MAX_TAPS);
        else
            len_eff = window_length_reg;
        room = mws_pkg::LEN_W'(mws_pkg::MAX_TAPS) - len_eff;
        if ({1'b0, passes_reg} > room)
            passes_eff = mws_pkg::PASS_W'(room);
        else
            passes_eff = passes_reg;
        if (num_sites_reg == '0)
            sites_eff = mws_pkg::NSITE_W'(1);
        else if (num_sites_reg > mws_pkg::NSITE_W'(mws_pkg::MAX_SITES))
            sites_eff = mws_pkg::NSITE_W'(mws_pkg::MAX_SITES);
        else
            sites_eff = num_sites_reg;
        base_sum = triangular_reg ? mws_pkg::tri_sum(len_eff) : mws_pkg::WGT_W'(len_eff);
        dvs_wide = {{mws_pkg::WGT_W{1'b0}}, base_sum} << passes_eff;
    end

    // Base window, one weight per tap
    always_comb
    begin
        for (int i = 0; i < mws_pkg::MAX_TAPS; i++)
        begin
            logic [mws_pkg::LEN_W-1:0] ii;
            logic [mws_pkg::LEN_W-1:0] up;
            logic [mws_pkg::LEN_W-1:0] dn;
            ii = mws_pkg::LEN_W'(i);
            up = ii + mws_pkg::LEN_W'(1);
            dn = len_eff - ii;
            if (ii >= len_eff)
                base_wgt[i] = '0;
            else if (!triangular_reg)
                base_wgt[i] = mws_pkg::WGT_W'(1);
            else
                base_wgt[i] = mws_pkg::WGT_W'((up < dn) ? up : dn);
        end
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_sites_reg     <= mws_pkg::NSITE_W'(1);
            window_length_reg <= mws_pkg::LEN_W'(1);
            triangular_reg    <= 1'b0;
            passes_reg        <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (mws_pkg::cfg_index_t'(cfg_index))
                mws_pkg::CFG_NUM_SITES:       num_sites_reg     <= cfg_data;
                mws_pkg::CFG_WINDOW_LENGTH:   window_length_reg <= cfg_data[mws_pkg::LEN_W-1:0];
                mws_pkg::CFG_TRIANGULAR:      triangular_reg    <= cfg_data[0];
                mws_pkg::CFG_BINOMIAL_PASSES: passes_reg        <= cfg_data[mws_pkg::PASS_W-1:0];
                default:                      passes_reg        <= passes_reg;
            endcase
        end
    end

    // Weight builder: load the base window, then convolve with [1,1] once per cycle
    assign bld_pass = (state_reg == mws_pkg::ST_BUILD) && !bld_init_reg
                      && (bld_cnt_reg != passes_eff);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bld_init_reg <= 1'b1;
            bld_cnt_reg  <= '0;
        end
        else
        begin
            bld_init_reg <= cfg_wr_en;
            if (bld_init_reg)
                bld_cnt_reg <= '0;
            else if (bld_pass)
                bld_cnt_reg <= bld_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (bld_init_reg)
        begin
            for (int i = 0; i < mws_pkg::MAX_TAPS; i++)
                wgts_reg[i] <= base_wgt[i];
            taps_reg <= mws_pkg::TAPS_W'(len_eff) + mws_pkg::TAPS_W'(passes_eff);
            dvs_reg  <= dvs_wide[mws_pkg::WGT_W-1:0];
        end
        else if (bld_pass)
        begin
            for (int i = 1; i < mws_pkg::MAX_TAPS; i++)
                wgts_reg[i] <= wgts_reg[i] + wgts_reg[i-1];
        end
    end

    // Item decode at transfer time
    assign accept   = site_valid && !site_stall;
    assign is_last  = ({1'b0, site_cnt_reg} + mws_pkg::NSITE_W'(1)) >= sites_eff;
    assign produce  = (frames_reg + mws_pkg::TAPS_W'(1)) >= taps_reg;
    assign cur_slot = oldest_reg + frames_reg[mws_pkg::SLOT_W-1:0];
    assign rd_slot  = base_reg + rd_cnt_reg[mws_pkg::SLOT_W-1:0];
    assign wr_addr  = {cur_slot, site_cnt_reg};
    assign rd_addr  = {rd_slot, site_reg};
    assign div_done = done_x && done_y && done_z;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        if (cfg_wr_en)
            state_next = mws_pkg::ST_BUILD;
        else
        begin
            unique case (state_reg)
                mws_pkg::ST_BUILD:
                    if (!bld_init_reg && (bld_cnt_reg == passes_eff))
                        state_next = mws_pkg::ST_IDLE;
                mws_pkg::ST_IDLE:
                    if (accept && produce)
                        state_next = mws_pkg::ST_ACC;
                mws_pkg::ST_ACC:
                    if (div_start)
                        state_next = mws_pkg::ST_DIV;
                mws_pkg::ST_DIV:
                    if (div_done)
                        state_next = mws_pkg::ST_HOLD;
                mws_pkg::ST_HOLD:
                    if (res_load)
                        state_next = mws_pkg::ST_IDLE;
                default:
                    state_next = mws_pkg::ST_BUILD;
            endcase
        end
    end

    // State outputs
    always_comb
    begin
        site_stall = (state_reg != mws_pkg::ST_IDLE);
        issue_en   = (state_reg == mws_pkg::ST_ACC) && (rd_cnt_reg < taps_reg);
        div_start  = (state_reg == mws_pkg::ST_ACC) && (rd_cnt_reg == taps_reg)
                     && !iss_vld_reg && !prd_vld_reg;
        res_load   = (state_reg == mws_pkg::ST_HOLD) && (!res_valid_reg || !res_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= mws_pkg::ST_BUILD;
        else
            state_reg <= state_next;
    end

    // Advance the stream position; restart on any configuration write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            site_cnt_reg <= '0;
            frames_reg   <= '0;
            oldest_reg   <= '0;
        end
        else if (cfg_wr_en)
        begin
            site_cnt_reg <= '0;
            frames_reg   <= '0;
            oldest_reg   <= '0;
        end
        else if (accept)
        begin
            if (is_last)
            begin
                site_cnt_reg <= '0;
                if (!produce)
                    frames_reg <= frames_reg + 1'b1;
                else
                    oldest_reg <= oldest_reg + 1'b1;
            end
            else
                site_cnt_reg <= site_cnt_reg + 1'b1;
        end
    end

    // History memory: write on transfer, read one tap per cycle while accumulating.
    // Only one item is in flight, so reads never overlap a write to the same entry.
    always_ff @(posedge clk)
    begin
        if (accept)
            hist_mem[wr_addr] <= site_pos;
        if (issue_en)
            rd_data_reg <= hist_mem[rd_addr];
    end

    // Tap read sequencing
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iss_vld_reg <= 1'b0;
            prd_vld_reg <= 1'b0;
            rd_cnt_reg  <= '0;
        end
        else
        begin
            iss_vld_reg <= issue_en;
            prd_vld_reg <= iss_vld_reg;
            if (accept)
                rd_cnt_reg <= '0;
            else if (issue_en)
                rd_cnt_reg <= rd_cnt_reg + 1'b1;
        end
    end

    // Capture item context, multiply, then accumulate
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            site_reg  <= site_cnt_reg;
            base_reg  <= oldest_reg;
            last_reg  <= is_last;
            acc_x_reg <= '0;
            acc_y_reg <= '0;
            acc_z_reg <= '0;
        end
        else if (prd_vld_reg)
        begin
            acc_x_reg <= acc_x_reg + prod_x_reg;
            acc_y_reg <= acc_y_reg + prod_y_reg;
            acc_z_reg <= acc_z_reg + prod_z_reg;
        end
        if (issue_en)
            wgt_pipe_reg <= wgts_reg[rd_cnt_reg[mws_pkg::SLOT_W-1:0]];
        if (iss_vld_reg)
        begin
            prod_x_reg <= mws_pkg::ACC_W'(signed'(rd_data_reg[3*mws_pkg::DATA_W-1:2*mws_pkg::DATA_W])
                          * signed'({1'b0, wgt_pipe_reg}));
            prod_y_reg <= mws_pkg::ACC_W'(signed'(rd_data_reg[2*mws_pkg::DATA_W-1:mws_pkg::DATA_W])
                          * signed'({1'b0, wgt_pipe_reg}));
            prod_z_reg <= mws_pkg::ACC_W'(signed'(rd_data_reg[mws_pkg::DATA_W-1:0])
                          * signed'({1'b0, wgt_pipe_reg}));
        end
    end

    // Rounding dividers, one per coordinate
    mws_div u_div_x (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_start),
        .acc    (acc_x_reg),
        .dvs    (dvs_reg),
        .done   (done_x),
        .result (quo_x)
    );

    mws_div u_div_y (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_start),
        .acc    (acc_y_reg),
        .dvs    (dvs_reg),
        .done   (done_y),
        .result (quo_y)
    );

    mws_div u_div_z (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_start),
        .acc    (acc_z_reg),
        .dvs    (dvs_reg),
        .done   (done_z),
        .result (quo_z)
    );

    // Result register: load from the dividers, drop on transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (res_load)
            res_valid_reg <= 1'b1;
        else if (!res_stall)
            res_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            res_item_reg.smooth_x    <= quo_x;
            res_item_reg.smooth_y    <= quo_y;
            res_item_reg.smooth_z    <= quo_z;
            res_item_reg.site_number <= site_reg;
            res_item_reg.frame_last  <= last_reg;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_item  = res_item_reg;

endmodule

`default_nettype wire

@@ src/mws_div.sv @@
// Rounding divider for one coordinate: |acc| / divisor rounded half away from zero,
// one quotient bit per cycle, saturated to Q16.16. Depends on mws_pkg.
`default_nettype none

module mws_div (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    input  wire logic signed [mws_pkg::ACC_W-1:0]  acc,
    input  wire logic [mws_pkg::WGT_W-1:0]         dvs,
    output logic                                   done,
    output logic signed [mws_pkg::DATA_W-1:0]      result
);

    logic                              busy_reg;
    logic                              done_reg;
    logic [mws_pkg::QCNT_W-1:0]        cnt_reg;
    logic [mws_pkg::DEN_W-1:0]         rem_reg;
    logic [mws_pkg::DEN_W-1:0]         rem_next;
    logic [mws_pkg::DEN_W-1:0]         den_reg;
    logic [mws_pkg::QUO_W-1:0]         low_reg;
    logic [mws_pkg::QUO_W-1:0]         quo_reg;
    logic [mws_pkg::QUO_W-1:0]         quo_next;
    logic                              neg_reg;
    logic signed [mws_pkg::DATA_W-1:0] result_reg;
    logic signed [mws_pkg::DATA_W-1:0] result_next;
    logic [mws_pkg::ACC_W-1:0]         mag;
    logic [mws_pkg::ACC_W-1:0]         num;
    logic [mws_pkg::DEN_W:0]           trial;
    logic                              ge;

    // Form 2*|acc| + d; the quotient by 2*d is the rounded result
    always_comb
    begin
        mag = acc[mws_pkg::ACC_W-1] ? mws_pkg::ACC_W'(-acc) : mws_pkg::ACC_W'(acc);
        num = {mag[mws_pkg::ACC_W-2:0], 1'b0} + mws_pkg::ACC_W'(dvs);
    end

    // One restoring step
    always_comb
    begin
        trial    = {rem_reg, low_reg[mws_pkg::QUO_W-1]};
        ge       = trial >= {1'b0, den_reg};
        rem_next = ge ? mws_pkg::DEN_W'(trial - {1'b0, den_reg}) : mws_pkg::DEN_W'(trial);
        quo_next = {quo_reg[mws_pkg::QUO_W-2:0], ge};
    end

    // Saturate the signed result
    always_comb
    begin
        if (neg_reg)
        begin
            if (quo_next > mws_pkg::QUO_W'(33'h080000000))
                result_next = {1'b1, {(mws_pkg::DATA_W-1){1'b0}}};
            else
                result_next = mws_pkg::DATA_W'(-quo_next);
        end
        else
        begin
            if (quo_next > mws_pkg::QUO_W'(33'h07FFFFFFF))
                result_next = {1'b0, {(mws_pkg::DATA_W-1){1'b1}}};
            else
                result_next = mws_pkg::DATA_W'(quo_next);
        end
    end

    // Control: load on start, then step until the last quotient bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == mws_pkg::QCNT_W'(mws_pkg::QUO_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= mws_pkg::DEN_W'(num[mws_pkg::ACC_W-1:mws_pkg::QUO_W]);
            low_reg <= num[mws_pkg::QUO_W-1:0];
            den_reg <= {dvs, 1'b0};
            neg_reg <= acc[mws_pkg::ACC_W-1];
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            low_reg <= {low_reg[mws_pkg::QUO_W-2:0], 1'b0};
            quo_reg <= quo_next;
            if (cnt_reg == mws_pkg::QCNT_W'(mws_pkg::QUO_W - 1))
                result_reg <= result_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

@@ src/mws_checker.sv @@
// Port-level checker for the multichannel window smoother and its bind to the top level.
// Depends on mws_pkg and multichannel_window_smoother_unit.
`default_nettype none

module mws_checker (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           site_valid,
    input wire logic                           site_stall,
    input wire logic                           res_valid,
    input wire logic                           res_stall,
    input wire mws_pkg::res_item_t             res_item,
    input wire logic                           cfg_wr_en
);

    // A stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res_item))
        else $error("stalled result dropped or changed");

    // A configuration write stalls the input for the weight build
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wr_en |=> site_stall)
        else $error("input not held off after configuration write");

    // A new result appears only while no item is being taken
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(site_stall))
        else $error("result loaded while idle");

    // The input side closes only after a transfer or a configuration write
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(site_stall) |-> $past(site_valid) || $past(cfg_wr_en))
        else $error("input stalled without cause");

endmodule

bind multichannel_window_smoother_unit mws_checker u_mws_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .site_valid (site_valid),
    .site_stall (site_stall),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .res_item   (res_item),
    .cfg_wr_en  (cfg_wr_en)
);

`default_nettype wire

@@ test/multichannel_window_smoother_unit_test.sv @@
// Self-checking testbench for multichannel_window_smoother_unit: a clocked driver and monitor
// around a predictor of the per-site FIR smoothing. Depends on mws_pkg and the RTL only.
`default_nettype none

module multichannel_window_smoother_unit_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE_CYCLES = 60;

    logic                           clk;
    logic                           rst_n;
    logic                           site_valid;
    logic                           site_stall;
    mws_pkg::pos_item_t             site_pos;
    logic                           res_valid;
    logic                           res_stall;
    mws_pkg::res_item_t             res_item;
    logic                           cfg_wr_en;
    logic [mws_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [mws_pkg::CFG_DATA_W-1:0] cfg_data;

    multichannel_window_smoother_unit u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .site_valid (site_valid),
        .site_stall (site_stall),
        .site_pos   (site_pos),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res_item   (res_item),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    // Smoother state mirrored for prediction
    logic [mws_pkg::DATA_W-1:0] hist_x [mws_pkg::MAX_TAPS][mws_pkg::MAX_SITES];
    logic [mws_pkg::DATA_W-1:0] hist_y [mws_pkg::MAX_TAPS][mws_pkg::MAX_SITES];
    logic [mws_pkg::DATA_W-1:0] hist_z [mws_pkg::MAX_TAPS][mws_pkg::MAX_SITES];
    longint            weight [mws_pkg::MAX_TAPS+1];
    int unsigned       slot_oldest;
    int unsigned       site_cnt;
    int unsigned       frames_have;
    int unsigned       taps_n;
    longint            weight_sum;
    int unsigned       sites_n;

    // Register shadows
    int unsigned reg_sites;
    int unsigned reg_len;
    int unsigned reg_tri;
    int unsigned reg_passes;

    mws_pkg::pos_item_t pending_pos[$];
    mws_pkg::res_item_t smoothed_due[$];
    int        gap_pct;
    int        stall_pct;
    int        mismatches;

    // Rebuild the tap weights and restart the frame stream
    function automatic void rebuild_window();
        int unsigned len;
        int unsigned passes;
        longint      sum;
        len = reg_len;
        passes = reg_passes;
        sum = 0;
        if (len < 1) len = 1;
        if (len > mws_pkg::MAX_TAPS) len = mws_pkg::MAX_TAPS;
        if (passes > mws_pkg::MAX_TAPS - len) passes = mws_pkg::MAX_TAPS - len;
        for (int i = 0; i <= mws_pkg::MAX_TAPS; i++) weight[i] = 0;
        if (reg_tri[0]) begin
            for (int i = 0; i < (len + 1) / 2; i++) begin
                weight[i] = i + 1;
                weight[len - 1 - i] = i + 1;
            end
        end else begin
            for (int i = 0; i < len; i++) weight[i] = 1;
        end
        for (int i = 0; i < len; i++) sum += weight[i];
        for (int p = 0; p < passes; p++) begin
            weight[len] = 0;
            for (int i = len; i > 0; i--) weight[i] += weight[i - 1];
            len++;
            sum *= 2;
        end
        taps_n = len;
        weight_sum = sum;
        sites_n = reg_sites;
        if (sites_n < 1) sites_n = 1;
        if (sites_n > mws_pkg::MAX_SITES) sites_n = mws_pkg::MAX_SITES;
        slot_oldest = 0;
        site_cnt = 0;
        frames_have = 0;
    endfunction

    // Divide by the weight sum, ties away from zero, saturate to Q16.16
    function automatic logic [mws_pkg::DATA_W-1:0] round_scaled(longint acc);
        longint mag;
        longint q;
        mag = (acc < 0) ? -acc : acc;
        q = (2 * mag + weight_sum) / (2 * weight_sum);
        if (acc < 0) q = -q;
        if (q > 64'sd2147483647) q = 64'sd2147483647;
        if (q < -64'sd2147483648) q = -64'sd2147483648;
        return q[mws_pkg::DATA_W-1:0];
    endfunction

    // Store one site and queue the smoothed position once the window is full
    function automatic void predict_smoothing(mws_pkg::pos_item_t p);
        int unsigned        site;
        int unsigned        cur;
        int unsigned        k;
        bit                 last;
        longint             ax;
        longint             ay;
        longint             az;
        mws_pkg::res_item_t r;
        site = site_cnt % mws_pkg::MAX_SITES;
        cur = (slot_oldest + frames_have) % mws_pkg::MAX_TAPS;
        last = (site_cnt + 1 >= sites_n);
        hist_x[cur][site] = p.pos_x;
        hist_y[cur][site] = p.pos_y;
        hist_z[cur][site] = p.pos_z;
        if (frames_have + 1 >= taps_n) begin
            ax = 0;
            ay = 0;
            az = 0;
            for (int s = 0; s < taps_n; s++) begin
                k = (slot_oldest + s) % mws_pkg::MAX_TAPS;
                ax += weight[s] * longint'(signed'(hist_x[k][site]));
                ay += weight[s] * longint'(signed'(hist_y[k][site]));
                az += weight[s] * longint'(signed'(hist_z[k][site]));
            end
            r.smooth_x = round_scaled(ax);
            r.smooth_y = round_scaled(ay);
            r.smooth_z = round_scaled(az);
            r.site_number = site[mws_pkg::SITE_W-1:0];
            r.frame_last = last;
            smoothed_due.push_back(r);
        end
        if (last) begin
            site_cnt = 0;
            if (frames_have + 1 < taps_n) frames_have++;
            else slot_oldest = (slot_oldest + 1) % mws_pkg::MAX_TAPS;
        end else begin
            site_cnt++;
        end
    endfunction

    function automatic logic [mws_pkg::DATA_W-1:0] rand_coord();
        case ($urandom_range(7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2, 3: return mws_pkg::DATA_W'($urandom_range(2000)) - 32'd1000;
            default: return $urandom;
        endcase
    endfunction

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Driver: present the oldest pending position, hold it while stalled
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            site_valid <= 1'b0;
            site_pos <= '0;
        end else begin
            if (site_valid && !site_stall) begin
                predict_smoothing(site_pos);
                void'(pending_pos.pop_front());
            end
            if (!(site_valid && site_stall)) begin
                if (pending_pos.size() > 0 && !($urandom_range(99) < gap_pct)) begin
                    site_valid <= 1'b1;
                    site_pos <= pending_pos[0];
                end else begin
                    site_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each result transfer against the oldest expectation
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            res_stall <= 1'b0;
        end else begin
            if (res_valid && !res_stall) begin
                if (smoothed_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: %p", res_item);
                end else begin
                    if (res_item.smooth_x !== smoothed_due[0].smooth_x
                        || res_item.smooth_y !== smoothed_due[0].smooth_y
                        || res_item.smooth_z !== smoothed_due[0].smooth_z
                        || res_item.site_number !== smoothed_due[0].site_number
                        || res_item.frame_last !== smoothed_due[0].frame_last) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %p actual %p",
                                     smoothed_due[0], res_item);
                    end
                    void'(smoothed_due.pop_front());
                end
            end
            res_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Write all four registers in consecutive cycles, then restart the mirror
    task automatic write_regs(int unsigned sites, int unsigned len, int unsigned tri_sel,
                              int unsigned passes);
        mws_pkg::cfg_index_t idx;
        int unsigned vals [4];
        vals = '{sites, len, tri_sel, passes};
        for (int i = 0; i < 4; i++) begin
            idx = mws_pkg::cfg_index_t'(i);
            @(posedge clk);
            cfg_wr_en <= 1'b1;
            cfg_index <= idx;
            cfg_data <= mws_pkg::CFG_DATA_W'(vals[i]);
        end
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        reg_sites = sites;
        reg_len = len;
        reg_tri = tri_sel;
        reg_passes = passes;
        rebuild_window();
    endtask

    task automatic drain_all();
        while (pending_pos.size() > 0 || smoothed_due.size() > 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic queue_random(int count);
        mws_pkg::pos_item_t p;
        for (int i = 0; i < count; i++) begin
            p.pos_x = rand_coord();
            p.pos_y = rand_coord();
            p.pos_z = rand_coord();
            pending_pos.push_back(p);
        end
    endtask

    task automatic run_phase(int unsigned sites, int unsigned len, int unsigned tri_sel,
                             int unsigned passes, int count, int gap, int stall);
        write_regs(sites, len, tri_sel, passes);
        gap_pct = gap;
        stall_pct = stall;
        queue_random(count);
        drain_all();
    endtask

    initial
    begin
        mws_pkg::pos_item_t p;
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        gap_pct = 0;
        stall_pct = 0;
        mismatches = 0;
        reg_sites = 1;
        reg_len = 1;
        reg_tri = 0;
        reg_passes = 0;
        rebuild_window();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: two-tap average over extremes and rounding ties
        write_regs(1, 2, 0, 0);
        begin
            logic [mws_pkg::DATA_W-1:0] seq [12];
            seq = '{32'h0, 32'h1, 32'h0, 32'hffff_ffff, 32'h0, 32'h8000_0000,
                    32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h3, 32'hffff_fffd,
                    32'hffff_fffe};
            foreach (seq[i]) begin
                p.pos_x = seq[i];
                p.pos_y = ~seq[i];
                p.pos_z = seq[11 - i];
                pending_pos.push_back(p);
            end
        end
        drain_all();

        // Zero registers act as one; large values clamp
        run_phase(0, 0, 0, 0, 30, 0, 0);
        run_phase(3, 16, 1, 0, 120, 88, 0);
        run_phase(5, 4, 1, 15, 150, 0, 88);
        run_phase(2, 31, 0, 15, 100, 24, 24);
        run_phase(4, 5, 1, 3, 150, 88, 0);

        // Pause the sender until every result is back, then resume the same stream
        write_regs(7, 3, 0, 2);
        gap_pct = 0;
        stall_pct = 30;
        queue_random(100);
        while (pending_pos.size() > 0 || smoothed_due.size() > 0) @(posedge clk);
        queue_random(100);
        drain_all();

        // Site count above range clamps, single tap: every transfer gives a result
        run_phase(8191, 1, 1, 0, 20, 0, 0);
        run_phase(6, 2, 0, 1, 80, 88, 88);

        if (mismatches == 0 && smoothed_due.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire
